@@ src/lztd_pkg.sv @@
// Package for the LZ77 token decoder: window and field sizes, and the
// command and status types between the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package lztd_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int MAX_MATCH   = 32;
   localparam int PTR_W       = $clog2(WINDOW_SIZE);
   localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
   localparam int DIST_W      = 13;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;

   typedef struct packed {
      logic accept;
      logic rd_first;
      logic rd_next;
      logic emit_lit;
      logic emit_err;
      logic emit_copy;
      logic last;
   } lztd_cmd_type;

   typedef struct packed {
      logic             is_match;
      logic             bad;
      logic             len_zero;
      logic             out_free;
      logic [LEN_W-1:0] len_sat;
   } lztd_sts_type;

endpackage

@@ src/lz77_token_decoder_top.sv @@
// Top level of the LZ77 token decoder: controller plus datapath.
// Depends on lztd_pkg, lztd_ctrl and lztd_dpath (which holds lztd_ram).
`timescale 1ns / 1ps

// One request is taken per token when the block is idle. A literal or a
// rejected distance is decoded and then emitted as one result, a pair with a
// good distance is decoded and then copied byte by byte for its length
// (length saturated at 32), and a zero-length pair gives no result. The copy
// rate of one byte per cycle while the output register is free is set by the
// single read port of the 4096-byte history RAM; the token decode issues the
// first read. Results leave through an output register, so a stalled result
// holds only the next byte. The history needs no clearing pass after reset.
module lz77_token_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_new_stream,
   input  logic                        req_token_is_match,
   input  logic [lztd_pkg::BYTE_W-1:0] req_literal_byte,
   input  logic [lztd_pkg::DIST_W-1:0] req_match_distance,
   input  logic [lztd_pkg::LEN_W-1:0]  req_match_length,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lztd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_bad_distance
);

   import lztd_pkg::*;

   lztd_cmd_type cmd;
   lztd_sts_type sts;

   lztd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lztd_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_new_stream     (req_new_stream),
      .req_token_is_match (req_token_is_match),
      .req_literal_byte   (req_literal_byte),
      .req_match_distance (req_match_distance),
      .req_match_length   (req_match_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_bad_distance   (rsp_bad_distance)
   );

endmodule

@@ src/lztd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module lztd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lztd_dpath.sv @@
// Datapath of the LZ77 token decoder: history RAM, pointers, byte count,
// token checks and the result register. Depends on lztd_pkg and lztd_ram.
`timescale 1ns / 1ps

module lztd_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  lztd_pkg::lztd_cmd_type        cmd,
   output lztd_pkg::lztd_sts_type        sts,
   input  logic                          req_new_stream,
   input  logic                          req_token_is_match,
   input  logic [lztd_pkg::BYTE_W-1:0]   req_literal_byte,
   input  logic [lztd_pkg::DIST_W-1:0]   req_match_distance,
   input  logic [lztd_pkg::LEN_W-1:0]    req_match_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lztd_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_bad_distance
);

   import lztd_pkg::*;

   localparam int EXT_W = (CNT_W > DIST_W) ? CNT_W + 1 : DIST_W + 1;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(WINDOW_SIZE - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [BYTE_W-1:0] lit_ff, lit_in;
   logic              byp_ff, byp_in;
   logic [BYTE_W-1:0] byp_data_ff, byp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [CNT_W-1:0]  count_eff;
   logic [EXT_W-1:0]  wp_ext, dist_ext, start_wide;
   logic [PTR_W-1:0]  start_addr;
   logic              rd_en, wr_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] ram_rdata, copy_byte, wr_data;
   logic              put;

   assign count_eff = req_new_stream ? '0 : count_ff;
   assign wp_ext    = EXT_W'(wp_ff);
   assign dist_ext  = EXT_W'(req_match_distance);

   always_comb begin
      if (wp_ext >= dist_ext) begin
         start_wide = wp_ext - dist_ext;
      end else begin
         start_wide = wp_ext + EXT_W'(WINDOW_SIZE) - dist_ext;
      end
   end

   assign start_addr = start_wide[PTR_W-1:0];

   always_comb begin
      sts.is_match = req_token_is_match;
      sts.bad      = (req_match_distance == '0) || (EXT_W'(req_match_distance) >
                     EXT_W'(count_eff));
      sts.len_zero = (req_match_length == '0);
      sts.out_free = !rsp_valid_ff || rsp_ready;
      if (req_match_length > LEN_W'(MAX_MATCH)) begin
         sts.len_sat = LEN_W'(MAX_MATCH);
      end else begin
         sts.len_sat = req_match_length;
      end
   end

   assign rd_en     = cmd.rd_first || cmd.rd_next;
   assign rd_addr   = cmd.rd_first ? start_addr : rp_ff;
   assign copy_byte = byp_ff ? byp_data_ff : ram_rdata;
   assign put       = cmd.emit_lit || cmd.emit_copy;
   assign wr_en     = put;
   assign wr_data   = cmd.emit_lit ? lit_ff : copy_byte;

   lztd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      wp_in        = wp_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      lit_in       = lit_ff;
      byp_in       = byp_ff;
      byp_data_in  = byp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (cmd.accept) begin
         lit_in = req_literal_byte;
         if (req_new_stream) begin
            count_in = '0;
         end
      end

      if (cmd.rd_first) begin
         rp_in = ptr_inc(start_addr);
      end else if (cmd.rd_next) begin
         rp_in = ptr_inc(rp_ff);
      end

      // A read of the entry written in the same cycle takes the new byte.
      if (rd_en) begin
         byp_in      = wr_en && (wp_ff == rd_addr);
         byp_data_in = wr_data;
      end

      if (put) begin
         wp_in = ptr_inc(wp_ff);
         if (count_ff < CNT_W'(WINDOW_SIZE)) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_lit || cmd.emit_err || cmd.emit_copy) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cmd.emit_err ? '0 : wr_data;
         rsp_last_in  = cmd.last;
         rsp_bad_in   = cmd.emit_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rp_ff       <= rp_in;
      lit_ff      <= lit_in;
      byp_ff      <= byp_in;
      byp_data_ff <= byp_data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_bad_distance = rsp_bad_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_SIZE))
      else $error("byte count exceeds the window");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lit || cmd.emit_err || cmd.emit_copy) |=> rsp_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule

@@ src/lztd_ctrl.sv @@
// Controller of the LZ77 token decoder: token decode state machine and
// copy length counter. Depends on lztd_pkg.
`timescale 1ns / 1ps

module lztd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lztd_pkg::lztd_sts_type sts,
   output lztd_pkg::lztd_cmd_type cmd
);

   import lztd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LIT  = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;
   localparam logic [1:0] ST_COPY = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] remain_ff, remain_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      cmd       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!sts.is_match) begin
                  state_in = ST_LIT;
               end else if (sts.bad) begin
                  state_in = ST_ERR;
               end else if (!sts.len_zero) begin
                  cmd.rd_first = 1'b1;
                  remain_in    = sts.len_sat;
                  state_in     = ST_COPY;
               end
            end
         end
         ST_LIT: begin
            if (sts.out_free) begin
               cmd.emit_lit = 1'b1;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (sts.out_free) begin
               cmd.emit_copy = 1'b1;
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == LEN_W'(1)) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lit || cmd.emit_err || cmd.emit_copy) |-> sts.out_free)
      else $error("result emitted into a full output register");

   a_copy_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (remain_ff != '0))
      else $error("copy state with nothing left to copy");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_lit, cmd.emit_err, cmd.emit_copy, cmd.accept}))
      else $error("conflicting controller commands");
`endif

endmodule

@@ verif/lz77_token_decoder_checker.sv @@
// Checker for the LZ77 token decoder: watches the request and result channels,
// expands each accepted token into the bytes it must produce and compares them.
// Depends on lztd_pkg for the field widths and window size.
`timescale 1ns / 1ps

module lz77_token_decoder_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_new_stream,
   input  logic                        req_token_is_match,
   input  logic [lztd_pkg::BYTE_W-1:0] req_literal_byte,
   input  logic [lztd_pkg::DIST_W-1:0] req_match_distance,
   input  logic [lztd_pkg::LEN_W-1:0]  req_match_length,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [lztd_pkg::BYTE_W-1:0] rsp_out_byte,
   input  logic                        rsp_last_of_run,
   input  logic                        rsp_bad_distance,
   output int                          mismatch_count,
   output int                          bytes_pending
);

   typedef struct packed {
      logic [lztd_pkg::BYTE_W-1:0] data;
      logic                        last;
      logic                        bad;
   } decoded_byte_type;

   decoded_byte_type              expected_bytes[$];
   logic [lztd_pkg::BYTE_W-1:0]   history_mem[0:lztd_pkg::WINDOW_SIZE-1];
   logic [lztd_pkg::PTR_W-1:0]    out_pos;
   int                            stream_fill;
   int                            fail_total;

   initial begin
      fail_total     = 0;
      mismatch_count = 0;
      bytes_pending  = 0;
      out_pos        = '0;
      stream_fill    = 0;
   end

   task report_mismatch(input string field, input logic [7:0] got, input logic [7:0] want);
      fail_total++;
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, field, got, want);
   endtask

   task append_byte(input logic [lztd_pkg::BYTE_W-1:0] value);
      history_mem[out_pos] = value;
      out_pos = out_pos + 1'b1;
      if (stream_fill < lztd_pkg::WINDOW_SIZE)
         stream_fill++;
   endtask

   task expand_token(input logic                        new_stream,
                     input logic                        is_match,
                     input logic [lztd_pkg::BYTE_W-1:0] literal,
                     input logic [lztd_pkg::DIST_W-1:0] distance,
                     input logic [lztd_pkg::LEN_W-1:0]  length);
      decoded_byte_type            entry;
      int                          run;
      int                          rd;
      logic [lztd_pkg::BYTE_W-1:0] value;
      if (new_stream)
         stream_fill = 0;
      if (!is_match) begin
         append_byte(literal);
         entry.data = literal;
         entry.last = 1'b1;
         entry.bad  = 1'b0;
         expected_bytes.push_back(entry);
         return;
      end
      if (distance == 0 || int'(distance) > stream_fill) begin
         entry.data = '0;
         entry.last = 1'b1;
         entry.bad  = 1'b1;
         expected_bytes.push_back(entry);
         return;
      end
      run = (int'(length) > lztd_pkg::MAX_MATCH) ? lztd_pkg::MAX_MATCH : int'(length);
      rd  = (int'(out_pos) - int'(distance) + lztd_pkg::WINDOW_SIZE) % lztd_pkg::WINDOW_SIZE;
      for (int k = 0; k < run; k++) begin
         value = history_mem[rd];
         append_byte(value);
         rd = (rd + 1) % lztd_pkg::WINDOW_SIZE;
         entry.data = value;
         entry.last = (k == run - 1);
         entry.bad  = 1'b0;
         expected_bytes.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         out_pos     = '0;
         stream_fill = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected result, out_byte", rsp_out_byte, 8'h00);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", {7'd0, rsp_last_of_run}, {7'd0, want.last});
               if (rsp_bad_distance !== want.bad)
                  report_mismatch("bad_distance", {7'd0, rsp_bad_distance}, {7'd0, want.bad});
            end
         end
         if (req_valid && req_ready)
            expand_token(req_new_stream, req_token_is_match, req_literal_byte,
                         req_match_distance, req_match_length);
      end
      mismatch_count <= fail_total;
      bytes_pending  <= expected_bytes.size();
   end

endmodule

@@ verif/tb_lz77_token_decoder_top.sv @@
// Testbench top for the LZ77 token decoder: drives directed and random tokens
// with random gaps and result stalls, and gives the verdict.
// Depends on lztd_pkg, lz77_token_decoder_top and lz77_token_decoder_checker.
`timescale 1ns / 1ps

module tb_lz77_token_decoder_top;

   localparam int   STALL_LIMIT   = 2000;
   localparam int   RANDOM_TOKENS = 430;
   localparam int   DRAIN_CYCLES  = 80;
   localparam logic TOKEN_LITERAL = 1'b0;
   localparam logic TOKEN_MATCH   = 1'b1;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_new_stream;
   logic                        req_token_is_match;
   logic [lztd_pkg::BYTE_W-1:0] req_literal_byte;
   logic [lztd_pkg::DIST_W-1:0] req_match_distance;
   logic [lztd_pkg::LEN_W-1:0]  req_match_length;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [lztd_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                        rsp_last_of_run;
   logic                        rsp_bad_distance;
   int                          mismatch_count;
   int                          bytes_pending;
   int                          stream_fill;
   bit                          window_filled;
   bit                          tx_burst;
   bit                          rx_burst;

   lz77_token_decoder_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_stream     (req_new_stream),
      .req_token_is_match (req_token_is_match),
      .req_literal_byte   (req_literal_byte),
      .req_match_distance (req_match_distance),
      .req_match_length   (req_match_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_bad_distance   (rsp_bad_distance)
   );

   lz77_token_decoder_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_stream     (req_new_stream),
      .req_token_is_match (req_token_is_match),
      .req_literal_byte   (req_literal_byte),
      .req_match_distance (req_match_distance),
      .req_match_length   (req_match_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_bad_distance   (rsp_bad_distance),
      .mismatch_count     (mismatch_count),
      .bytes_pending      (bytes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_token(input logic                        new_stream,
                             input logic                        is_match,
                             input logic [lztd_pkg::BYTE_W-1:0] literal,
                             input logic [lztd_pkg::DIST_W-1:0] distance,
                             input logic [lztd_pkg::LEN_W-1:0]  length);
      int gap;
      int run;
      if ($urandom_range(0, 15) == 0)
         tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_new_stream     <= new_stream;
      req_token_is_match <= is_match;
      req_literal_byte   <= literal;
      req_match_distance <= distance;
      req_match_length   <= length;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      if (new_stream)
         stream_fill = 0;
      if (is_match == TOKEN_LITERAL) begin
         stream_fill = stream_fill + 1;
      end else if (distance != 0 && int'(distance) <= stream_fill) begin
         run = (int'(length) > lztd_pkg::MAX_MATCH) ? lztd_pkg::MAX_MATCH : int'(length);
         stream_fill = stream_fill + run;
      end
      if (stream_fill >= lztd_pkg::WINDOW_SIZE) begin
         stream_fill   = lztd_pkg::WINDOW_SIZE;
         window_filled = 1'b1;
      end
   endtask

   task automatic send_random_token();
      logic                        new_stream;
      logic                        is_match;
      logic [lztd_pkg::BYTE_W-1:0] literal;
      logic [lztd_pkg::DIST_W-1:0] distance;
      logic [lztd_pkg::LEN_W-1:0]  length;
      int                          fill;
      int                          pick;
      new_stream = window_filled ? ($urandom_range(0, 24) == 0) : 1'b0;
      fill       = new_stream ? 0 : stream_fill;
      if (fill == 0)
         is_match = ($urandom_range(0, 3) == 0) ? TOKEN_MATCH : TOKEN_LITERAL;
      else
         is_match = ($urandom_range(0, 99) < 75) ? TOKEN_MATCH : TOKEN_LITERAL;
      literal  = 8'($urandom);
      distance = 13'($urandom);
      length   = 6'($urandom);
      if (is_match == TOKEN_MATCH) begin
         pick = $urandom_range(0, 99);
         if (fill == 0 || pick < 10)
            distance = $urandom_range(0, 1) ? '0 : 13'($urandom_range(fill + 1, 8191));
         else if (pick < 45)
            distance = 13'($urandom_range(1, (fill < 8) ? fill : 8));
         else if (pick < 55)
            distance = 13'(fill);
         else
            distance = 13'($urandom_range(1, fill));
         pick = $urandom_range(0, 99);
         if (pick < 3)
            length = '0;
         else if (pick < 15)
            length = 6'($urandom_range(lztd_pkg::MAX_MATCH + 1, 63));
         else if (pick < 40)
            length = 6'($urandom_range(1, 8));
         else
            length = 6'($urandom_range(9, lztd_pkg::MAX_MATCH));
      end
      send_token(new_stream, is_match, literal, distance, length);
   endtask

   initial begin
      int hold;
      rsp_ready = 1'b0;
      rx_burst  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rx_burst = !rx_burst;
         hold = rx_burst ? 0 : $urandom_range(0, 7);
         repeat (hold) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      wait (!reset);
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_valid          = 1'b0;
      req_new_stream     = 1'b0;
      req_token_is_match = TOKEN_LITERAL;
      req_literal_byte   = '0;
      req_match_distance = '0;
      req_match_length   = '0;
      stream_fill        = 0;
      window_filled      = 1'b0;
      tx_burst           = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed tokens: rejected distances, literal extremes, overlapping and
      // saturated copies, a zero-length copy and new-stream restarts.
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd1,    6'd1);
      send_token(1'b0, TOKEN_MATCH,   8'hFF, 13'd0,    6'd5);
      send_token(1'b0, TOKEN_LITERAL, 8'h00, 13'd8191, 6'd63);
      send_token(1'b0, TOKEN_LITERAL, 8'hFF, 13'd0,    6'd0);
      send_token(1'b0, TOKEN_LITERAL, 8'hA5, 13'd4096, 6'd32);
      send_token(1'b0, TOKEN_LITERAL, 8'h5A, 13'd1,    6'd1);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd1,    6'd1);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd5,    6'd4);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd10,   6'd3);
      send_token(1'b0, TOKEN_MATCH,   8'hFF, 13'd1,    6'd32);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd3,    6'd32);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd2,    6'd0);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd7,    6'd63);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd8191, 6'd10);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd4096, 6'd32);
      send_token(1'b1, TOKEN_LITERAL, 8'h3C, 13'd0,    6'd0);
      send_token(1'b1, TOKEN_MATCH,   8'h00, 13'd1,    6'd4);
      send_token(1'b0, TOKEN_LITERAL, 8'hC3, 13'd0,    6'd0);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd1,    6'd33);
      send_token(1'b0, TOKEN_MATCH,   8'h00, 13'd33,   6'd2);
      send_token(1'b0, TOKEN_LITERAL, 8'h81, 13'd0,    6'd0);

      repeat (RANDOM_TOKENS) send_random_token();
      req_valid <= 1'b0;

      do @(posedge clock); while (bytes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ lz77_token_decoder_top.f @@
src/lztd_pkg.sv
src/lztd_ram.sv
src/lztd_dpath.sv
src/lztd_ctrl.sv
src/lz77_token_decoder_top.sv
verif/lz77_token_decoder_checker.sv
verif/tb_lz77_token_decoder_top.sv
